// ----- src/ifr_pkg.sv -----
`timescale 1ns / 1ps

package ifr_pkg;

  localparam int COMP_BITS = 8;
  localparam int DIM_BITS  = 9;
  localparam int REG_BITS  = 2;

  localparam logic [DIM_BITS-1:0] DIM_RESET = 9'd256;

  typedef enum logic [1:0] {
    MODE_FLIP_H    = 2'd0,
    MODE_FLIP_V    = 2'd1,
    MODE_ROT_LEFT  = 2'd2,
    MODE_ROT_RIGHT = 2'd3
  } mode_t;

  localparam logic [REG_BITS-1:0] REG_MODE   = 2'd0;
  localparam logic [REG_BITS-1:0] REG_WIDTH  = 2'd1;
  localparam logic [REG_BITS-1:0] REG_HEIGHT = 2'd2;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [COMP_BITS-1:0] red_in;
    logic [COMP_BITS-1:0] green_in;
    logic [COMP_BITS-1:0] blue_in;
  } cmd_t;

  typedef struct packed {
    logic [COMP_BITS-1:0] red_out;
    logic [COMP_BITS-1:0] green_out;
    logic [COMP_BITS-1:0] blue_out;
    logic                 last_pixel;
  } result_t;

endpackage

// ----- src/ifr_ram.sv -----
`timescale 1ns / 1ps

module ifr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- src/image_flip_rotate_engine.sv -----
`timescale 1ns / 1ps

// Channel   | Direction | Signals                               | Handshake
// ----------+-----------+---------------------------------------+---------------------------
// command   | in        | cmd (kind, red/green/blue_in)         | start && !busy
// result    | out       | result (red/green/blue_out, last)     | strobe, one cycle, no stall
// config    | in        | cfg_index, cfg_data                   | cfg_write
//
// One word is taken per cycle while busy is low; busy is set during reset and cleared once it ends.
// A read word passes the coordinate stage, the address multiply-add stage, then the
// single frame store port with registered read, before its result returns.
// Loads and reads share that one store port in order, so no forwarding is needed.
// rst is synchronous; the frame store is not cleared. The receiver cannot stall.

module image_flip_rotate_engine #(
  parameter int MAX_WIDTH      = 256,
  parameter int MAX_HEIGHT     = 256,
  parameter int COMPONENT_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  ifr_pkg::cmd_t                  cmd,
  output logic                           strobe,
  output ifr_pkg::result_t               result,
  input  logic                           cfg_write,
  input  logic [ifr_pkg::REG_BITS-1:0]   cfg_index,
  input  logic [ifr_pkg::DIM_BITS-1:0]   cfg_data
);

  import ifr_pkg::*;

  localparam int DIM_MAX = (1 << DIM_BITS) - 1;
  localparam int W_CAP   = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
  localparam int H_CAP   = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
  localparam int DEPTH   = W_CAP * H_CAP;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CB      = (COMPONENT_BITS > COMP_BITS) ? COMP_BITS : COMPONENT_BITS;
  localparam int SW      = 3 * CB;

  mode_t               mode;
  logic [DIM_BITS-1:0] image_width;
  logic [DIM_BITS-1:0] image_height;

  logic [DIM_BITS-1:0] load_row;
  logic [DIM_BITS-1:0] load_col;
  logic [DIM_BITS-1:0] read_row;
  logic [DIM_BITS-1:0] read_col;

  logic [DIM_BITS-1:0] w_eff;
  logic [DIM_BITS-1:0] h_eff;
  logic [DIM_BITS-1:0] out_w;
  logic [DIM_BITS-1:0] out_h;
  logic                rotating;
  logic                accept;

  logic [DIM_BITS-1:0] lr;
  logic [DIM_BITS-1:0] lc;
  logic [DIM_BITS-1:0] rr;
  logic [DIM_BITS-1:0] rc;
  logic [DIM_BITS-1:0] orow;
  logic [DIM_BITS-1:0] ocol;
  logic [DIM_BITS-1:0] row_sel;
  logic [DIM_BITS-1:0] col_sel;
  logic                rd_last;

  logic [DIM_BITS-1:0] load_row_next;
  logic [DIM_BITS-1:0] load_col_next;
  logic [DIM_BITS-1:0] read_row_next;
  logic [DIM_BITS-1:0] read_col_next;

  logic                s1_valid;
  logic                s1_kind;
  logic [DIM_BITS-1:0] s1_row;
  logic [DIM_BITS-1:0] s1_col;
  logic [DIM_BITS-1:0] s1_width;
  logic [SW-1:0]       s1_pixel;
  logic                s1_last;

  logic [2*DIM_BITS-1:0] s1_sum;

  logic                s2_valid;
  logic                s2_kind;
  logic [AW-1:0]       s2_addr;
  logic [SW-1:0]       s2_pixel;
  logic                s2_last;

  logic                s3_valid;
  logic                s3_last;
  logic [SW-1:0]       rdata;
  logic                ram_we;
  logic                ram_re;

  assign accept = start && !busy;

  always_comb begin
    if (image_width == '0) begin
      w_eff = DIM_BITS'(1);
    end else if (image_width > DIM_BITS'(W_CAP)) begin
      w_eff = DIM_BITS'(W_CAP);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = DIM_BITS'(1);
    end else if (image_height > DIM_BITS'(H_CAP)) begin
      h_eff = DIM_BITS'(H_CAP);
    end else begin
      h_eff = image_height;
    end
  end

  assign rotating = (mode == MODE_ROT_LEFT) || (mode == MODE_ROT_RIGHT);
  assign out_w    = rotating ? h_eff : w_eff;
  assign out_h    = rotating ? w_eff : h_eff;

  assign lr = (load_row >= h_eff) ? '0 : load_row;
  assign lc = (load_col >= w_eff) ? '0 : load_col;
  assign rr = (read_row >= out_h) ? '0 : read_row;
  assign rc = (read_col >= out_w) ? '0 : read_col;

  always_comb begin
    case (mode)
      MODE_FLIP_H: begin
        orow = lr;
        ocol = w_eff - 1'b1 - lc;
      end
      MODE_FLIP_V: begin
        orow = h_eff - 1'b1 - lr;
        ocol = lc;
      end
      MODE_ROT_LEFT: begin
        orow = w_eff - 1'b1 - lc;
        ocol = lr;
      end
      MODE_ROT_RIGHT: begin
        orow = lc;
        ocol = h_eff - 1'b1 - lr;
      end
      default: begin
        orow = lr;
        ocol = lc;
      end
    endcase
  end

  assign rd_last = (rr == out_h - 1'b1) && (rc == out_w - 1'b1);
  assign row_sel = (cmd.kind == KIND_READ) ? rr : orow;
  assign col_sel = (cmd.kind == KIND_READ) ? rc : ocol;

  // advance source and output raster counters
  always_comb begin
    load_row_next = lr;
    load_col_next = lc + 1'b1;
    if (load_col_next >= w_eff) begin
      load_col_next = '0;
      load_row_next = lr + 1'b1;
      if (load_row_next >= h_eff) begin
        load_row_next = '0;
      end
    end
    read_row_next = rr;
    read_col_next = rc + 1'b1;
    if (read_col_next >= out_w) begin
      read_col_next = '0;
      read_row_next = rr + 1'b1;
      if (read_row_next >= out_h) begin
        read_row_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_FLIP_H;
      image_width  <= DIM_RESET;
      image_height <= DIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODE:   mode         <= mode_t'(cfg_data[1:0]);
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      load_row <= '0;
      load_col <= '0;
      read_row <= '0;
      read_col <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      busy     <= 1'b0;
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= ram_re;
      if (accept) begin
        if (cmd.kind == KIND_READ) begin
          read_row <= read_row_next;
          read_col <= read_col_next;
        end else begin
          load_row <= load_row_next;
          load_col <= load_col_next;
        end
      end
    end
  end

  assign s1_sum = s1_row * s1_width + {{DIM_BITS{1'b0}}, s1_col};

  always_ff @(posedge clk) begin
    s1_kind  <= cmd.kind;
    s1_row   <= row_sel;
    s1_col   <= col_sel;
    s1_width <= out_w;
    s1_pixel <= {cmd.red_in[CB-1:0], cmd.green_in[CB-1:0], cmd.blue_in[CB-1:0]};
    s1_last  <= rd_last;
    s2_kind  <= s1_kind;
    s2_addr  <= s1_sum[AW-1:0];
    s2_pixel <= s1_pixel;
    s2_last  <= s1_last;
    s3_last  <= s2_last;
  end

  assign ram_we = s2_valid && (s2_kind == KIND_LOAD);
  assign ram_re = s2_valid && (s2_kind == KIND_READ);

  ifr_ram #(
    .WIDTH(SW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (s2_addr),
    .wdata(s2_pixel),
    .rdata(rdata)
  );

  assign strobe            = s3_valid;
  assign result.red_out    = COMP_BITS'(rdata[3*CB-1:2*CB]);
  assign result.green_out  = COMP_BITS'(rdata[2*CB-1:CB]);
  assign result.blue_out   = COMP_BITS'(rdata[CB-1:0]);
  assign result.last_pixel = s3_last;

  a_read_returns: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.kind == KIND_READ) |=> ##2 strobe)
    else $error("read word produced no result");

  a_result_has_read: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(accept && cmd.kind == KIND_READ, 3))
    else $error("result without a read word");

  a_addr_in_store: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (s2_addr < AW'(DEPTH - 1) || s2_addr == AW'(DEPTH - 1)))
    else $error("store address beyond depth");

  a_read_col_bound: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.kind == KIND_READ) |=> (read_col < $past(out_w)))
    else $error("read column left the output width");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import ifr_pkg::*;

  localparam int GAP_MAX        = 11;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TARGET_WORDS   = 850;
  localparam int MAX_DIM        = 256;
  localparam int SMALL_DIM      = 9;
  localparam logic [REG_BITS-1:0] REG_NONE = 2'd3;

  class frame_scoreboard;
    logic [23:0] frame [MAX_DIM*MAX_DIM];
    bit          written [MAX_DIM*MAX_DIM];
    mode_t       mode;
    logic [DIM_BITS-1:0] width_reg;
    logic [DIM_BITS-1:0] height_reg;
    int unsigned load_row, load_col, read_row, read_col;
    result_t     pixels_due [$];
    int          errors;

    function new();
      mode       = MODE_FLIP_H;
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      load_row   = 0;
      load_col   = 0;
      read_row   = 0;
      read_col   = 0;
      errors     = 0;
    endfunction

    function void set_reg(logic [REG_BITS-1:0] idx, logic [DIM_BITS-1:0] data);
      case (idx)
        REG_MODE:   mode = mode_t'(data[1:0]);
        REG_WIDTH:  width_reg = data;
        REG_HEIGHT: height_reg = data;
        default: ;
      endcase
    endfunction

    function int unsigned clamp_dim(logic [DIM_BITS-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
    endfunction

    function void get_dims(output int unsigned w, h, ow, oh);
      bit turned;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      turned = (mode == MODE_ROT_LEFT) || (mode == MODE_ROT_RIGHT);
      ow = turned ? h : w;
      oh = turned ? w : h;
    endfunction

    function int unsigned frame_pixels();
      int unsigned w, h, ow, oh;
      get_dims(w, h, ow, oh);
      return w * h;
    endfunction

    function bit small_frame();
      int unsigned w, h, ow, oh;
      get_dims(w, h, ow, oh);
      return (w <= SMALL_DIM) && (h <= SMALL_DIM);
    endfunction

    function int unsigned next_read_addr();
      int unsigned w, h, ow, oh, r, c;
      get_dims(w, h, ow, oh);
      r = (read_row >= oh) ? 0 : read_row;
      c = (read_col >= ow) ? 0 : read_col;
      return r * ow + c;
    endfunction

    function bit read_ok();
      return written[next_read_addr()];
    endfunction

    function void note(cmd_t c);
      int unsigned w, h, ow, oh, r, col, orow, ocol, addr;
      result_t px;
      get_dims(w, h, ow, oh);
      if (c.kind == KIND_LOAD) begin
        r   = (load_row >= h) ? 0 : load_row;
        col = (load_col >= w) ? 0 : load_col;
        case (mode)
          MODE_FLIP_H: begin
            orow = r;
            ocol = w - 1 - col;
          end
          MODE_FLIP_V: begin
            orow = h - 1 - r;
            ocol = col;
          end
          MODE_ROT_LEFT: begin
            orow = w - 1 - col;
            ocol = r;
          end
          default: begin
            orow = col;
            ocol = h - 1 - r;
          end
        endcase
        addr = orow * ow + ocol;
        frame[addr]   = {c.red_in, c.green_in, c.blue_in};
        written[addr] = 1'b1;
        load_row = r;
        load_col = col + 1;
        if (load_col >= w) begin
          load_col = 0;
          load_row = r + 1;
          if (load_row >= h) load_row = 0;
        end
      end else begin
        addr = next_read_addr();
        r    = addr / ow;
        col  = addr % ow;
        px.red_out    = frame[addr][23:16];
        px.green_out  = frame[addr][15:8];
        px.blue_out   = frame[addr][7:0];
        px.last_pixel = (r == oh - 1) && (col == ow - 1);
        pixels_due.push_back(px);
        read_row = r;
        read_col = col + 1;
        if (read_col >= ow) begin
          read_col = 0;
          read_row = r + 1;
          if (read_row >= oh) read_row = 0;
        end
      end
    endfunction

    function void check(result_t got);
      result_t want;
      if (pixels_due.size() == 0) begin
        $error("pixel with no read waiting: %h", got);
        errors++;
        return;
      end
      want = pixels_due.pop_front();
      if (got.red_out !== want.red_out) begin
        $error("red_out: expected %0d, got %0d", want.red_out, got.red_out);
        errors++;
      end
      if (got.green_out !== want.green_out) begin
        $error("green_out: expected %0d, got %0d", want.green_out, got.green_out);
        errors++;
      end
      if (got.blue_out !== want.blue_out) begin
        $error("blue_out: expected %0d, got %0d", want.blue_out, got.blue_out);
        errors++;
      end
      if (got.last_pixel !== want.last_pixel) begin
        $error("last_pixel: expected %0d, got %0d", want.last_pixel, got.last_pixel);
        errors++;
      end
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                start     = 1'b0;
  cmd_t                cmd       = '0;
  logic                cfg_write = 1'b0;
  logic [REG_BITS-1:0] cfg_index = '0;
  logic [DIM_BITS-1:0] cfg_data  = '0;
  logic                busy;
  logic                strobe;
  result_t             result;

  frame_scoreboard sb;
  int              words_taken = 0;
  int              idle_count  = 0;
  bit              gaps_on     = 1'b1;

  always #6 clk = ~clk;

  image_flip_rotate_engine dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .strobe    (strobe),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always @(posedge clk) begin
    if (!rst && strobe) sb.check(result);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || cfg_write) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  task automatic issue(cmd_t c);
    int gap;
    gap = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    sb.note(c);
    words_taken++;
  endtask

  task automatic load_pixel(logic [23:0] rgb);
    cmd_t c;
    c.kind = KIND_LOAD;
    {c.red_in, c.green_in, c.blue_in} = rgb;
    issue(c);
  endtask

  task automatic read_pixel();
    cmd_t c;
    c.kind     = KIND_READ;
    c.red_in   = 8'($urandom);
    c.green_in = 8'($urandom);
    c.blue_in  = 8'($urandom);
    issue(c);
  endtask

  // never read a store entry that has not been written yet
  task automatic read_or_load();
    if (sb.read_ok()) read_pixel();
    else load_pixel(24'($urandom));
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.pixels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_BITS-1:0] idx, logic [DIM_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(mode_t m, logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h,
                           bit set_w, bit set_h);
    logic [6:0] junk;
    settle();
    junk = 7'($urandom);
    write_reg(REG_MODE, {junk, m});
    if (set_w) write_reg(REG_WIDTH, w);
    if (set_h) write_reg(REG_HEIGHT, h);
    if ($urandom_range(0, 5) == 0) write_reg(REG_NONE, 9'($urandom));
    cfg_write <= 1'b0;
  endtask

  task automatic frame_run(int unsigned extra);
    int unsigned n;
    n = sb.frame_pixels();
    repeat (n) load_pixel(24'($urandom));
    repeat (n + extra) read_or_load();
  endtask

  initial begin
    int unsigned w, h, n, t;
    bit          set_w, set_h;
    mode_t       m;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    configure(MODE_FLIP_H, 9'd3, 9'd2, 1'b1, 1'b1);
    load_pixel(24'h000000);
    load_pixel(24'hFFFFFF);
    load_pixel(24'hFF0000);
    load_pixel(24'h00FF00);
    load_pixel(24'h0000FF);
    load_pixel(24'h5AA5C3);
    repeat (6) read_pixel();
    configure(MODE_FLIP_V, '0, '0, 1'b0, 1'b0);
    repeat (4) read_pixel();
    configure(MODE_ROT_RIGHT, '0, '0, 1'b0, 1'b0);
    repeat (6) read_pixel();
    configure(MODE_ROT_LEFT, 9'd0, 9'd0, 1'b1, 1'b1);
    load_pixel(24'($urandom));
    repeat (2) read_pixel();

    gaps_on = 1'b0;
    configure(MODE_ROT_RIGHT, 9'd511, 9'd1, 1'b1, 1'b1);
    frame_run(0);

    while (words_taken < TARGET_WORDS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      m = mode_t'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(200, 511);
        h = $urandom_range(0, 1);
        if ($urandom_range(0, 1) == 1) begin
          t = w;
          w = h;
          h = t;
        end
        set_w = 1'b1;
        set_h = 1'b1;
      end else begin
        w = $urandom_range(0, SMALL_DIM);
        h = $urandom_range(0, SMALL_DIM);
        set_w = !sb.small_frame() || ($urandom_range(0, 3) != 0);
        set_h = !sb.small_frame() || ($urandom_range(0, 3) != 0);
      end
      configure(m, 9'(w), 9'(h), set_w, set_h);
      case ($urandom_range(0, 4))
        0: begin
          repeat ($urandom_range(5, 30)) begin
            if ($urandom_range(0, 1) == 1) read_or_load();
            else load_pixel(24'($urandom));
          end
        end
        1: begin
          n = sb.frame_pixels();
          repeat (n) load_pixel(24'($urandom));
          repeat (n / 2) read_or_load();
          configure(mode_t'($urandom_range(0, 3)), '0, '0, 1'b0, 1'b0);
          repeat (n - n / 2 + $urandom_range(0, 4)) read_or_load();
        end
        default: frame_run($urandom_range(0, 6));
      endcase
    end

    settle();
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
